### hw/rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the frame receiver RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every rising clock edge outside of reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Expression must never be true at a rising clock edge outside of reset.
`define ASSERT_NEVER(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

`endif

### hw/rtl/hdlcrx_pkg.sv
// ---------------------------------------------------------------------------
// hdlcrx_pkg
// Constants, codes and shared types of the HDLC-like frame receiver.
// ---------------------------------------------------------------------------
package hdlcrx_pkg;

  // Frame store geometry.
  localparam int BUFFER_DEPTH = 64;
  localparam int ADDR_W       = $clog2(BUFFER_DEPTH);
  localparam int CNT_W        = $clog2(BUFFER_DEPTH + 1);

  // Field and register widths.
  localparam int BYTE_W    = 8;
  localparam int TICK_W    = 10;
  localparam int TIMER_W   = 16;
  localparam int MIN_W     = 7;
  localparam int CFG_W     = 16;
  localparam int IN_DATA_W = 24;
  localparam int KIND_W    = 2;

  // Line codes.
  localparam logic [BYTE_W-1:0] FLAG_BYTE   = 8'h7E;
  localparam logic [BYTE_W-1:0] ESC_BYTE    = 8'h7D;
  localparam logic [BYTE_W-1:0] ESC_OF_FLAG = 8'h5E;
  localparam logic [BYTE_W-1:0] ESC_OF_ESC  = 8'h5D;

  // CRC-16/CCITT, processed one nibble per cycle.
  localparam logic [15:0] CRC_INIT  = 16'hFFFF;
  localparam logic [15:0] CRC_POLY  = 16'h1021;
  localparam int          DIGIT_W   = 4;
  localparam int          NIB_STEPS = BYTE_W / DIGIT_W;
  localparam int          STEP_W    = $clog2(NIB_STEPS + 1);

  // Receive phases.
  localparam logic [1:0] PH_HUNT = 2'd0;
  localparam logic [1:0] PH_BODY = 2'd1;
  localparam logic [1:0] PH_ESC  = 2'd2;

  // Result kinds.
  localparam logic [KIND_W-1:0] KIND_BYTE    = 2'd0;
  localparam logic [KIND_W-1:0] KIND_CRC_ERR = 2'd1;
  localparam logic [KIND_W-1:0] KIND_ESC_ERR = 2'd2;

  // Input item kinds.
  localparam logic FUNC_BYTE = 1'b0;
  localparam logic FUNC_TICK = 1'b1;

  // Configuration register indexes and reset values.
  localparam logic REG_IDLE_TIMEOUT  = 1'b0;
  localparam logic REG_MIN_FRAME_LEN = 1'b1;
  localparam logic [TIMER_W-1:0] IDLE_TIMEOUT_RST = 16'd20;
  localparam logic [MIN_W-1:0]   MIN_FRAME_RST    = 7'd12;

  // Command to the serial CRC unit.
  typedef struct packed {
    logic              start;
    logic              clear;
    logic [BYTE_W-1:0] data;
  } crc_cmd_t;

  // Write request to the frame store.
  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [BYTE_W-1:0] data;
  } store_wr_t;

endpackage

### hw/rtl/hdlcrx_crc.sv
// ---------------------------------------------------------------------------
// hdlcrx_crc
// Digit-serial CRC-16/CCITT unit, one nibble of the byte per cycle.
// ---------------------------------------------------------------------------
module hdlcrx_crc (
  input  logic                 clk,
  input  logic                 rst,
  input  hdlcrx_pkg::crc_cmd_t cmd,
  output logic [15:0]          crc,
  output logic                 busy
);

  logic [hdlcrx_pkg::BYTE_W-1:0] sreg;
  logic [hdlcrx_pkg::STEP_W-1:0] left;

  function automatic logic [15:0] crc_nib(input logic [15:0] c,
                                          input logic [hdlcrx_pkg::DIGIT_W-1:0] n);
    logic [15:0] r;
    r = c ^ {n, {(16 - hdlcrx_pkg::DIGIT_W){1'b0}}};
    for (int i = 0; i < hdlcrx_pkg::DIGIT_W; i++) begin
      r = r[15] ? ({r[14:0], 1'b0} ^ hdlcrx_pkg::CRC_POLY) : {r[14:0], 1'b0};
    end
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      crc  <= hdlcrx_pkg::CRC_INIT;
      left <= '0;
    end else if (cmd.start) begin
      crc  <= cmd.clear ? hdlcrx_pkg::CRC_INIT : crc;
      left <= hdlcrx_pkg::STEP_W'(hdlcrx_pkg::NIB_STEPS);
    end else if (cmd.clear) begin
      crc <= hdlcrx_pkg::CRC_INIT;
    end else if (left != '0) begin
      crc  <= crc_nib(crc, sreg[hdlcrx_pkg::BYTE_W-1 -: hdlcrx_pkg::DIGIT_W]);
      left <= left - 1'b1;
    end
  end

  // Most significant nibble goes first.
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      sreg <= cmd.data;
    end else if (left != '0) begin
      sreg <= sreg << hdlcrx_pkg::DIGIT_W;
    end
  end

  assign busy = (left != '0);

endmodule

### hw/rtl/hdlcrx_store.sv
// ---------------------------------------------------------------------------
// hdlcrx_store
// Frame store: one write port, one read port with registered read data.
// ---------------------------------------------------------------------------
module hdlcrx_store (
  input  logic                              clk,
  input  hdlcrx_pkg::store_wr_t             wr,
  input  logic [hdlcrx_pkg::ADDR_W-1:0]     raddr,
  output logic [hdlcrx_pkg::BYTE_W-1:0]     rdata
);

  logic [hdlcrx_pkg::BYTE_W-1:0] mem [hdlcrx_pkg::BUFFER_DEPTH];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

### hw/rtl/hdlc_like_frame_receiver_crc_check_top.sv
// ---------------------------------------------------------------------------
// hdlc_like_frame_receiver_crc_check_top
// Byte-stuffed frame receiver with CRC-16/CCITT check and frame release.
// ---------------------------------------------------------------------------
// Usage. The slave stream carries one request per line byte or timer tick:
// s_tuser selects a line byte (0) or a tick (1), s_tdata holds the byte and
// the elapsed milliseconds. The master stream returns frame bytes and
// notices; m_tuser gives the kind and m_tlast marks the final result caused
// by one request. The cfg port writes the idle timeout and minimum frame
// length. The user writes them only while the block is idle; it is not enforced.
// Flow. A byte that is stored is also fed to the nibble-serial CRC unit,
// which holds s_tready low while it works. A closing flag of a good frame
// of N bytes releases them from the frame store one byte at a time: a
// registered memory read in ST_LOAD, then the output register in ST_OUT,
// which waits for m_tready before the next read. A notice loads the output
// register straight from its request. s_tready stays low while any result
// is pending, so a stalled receiver on the master side holds the input
// side. Reset clears the phase, the byte count, the CRC and the idle timer
// and loads the register defaults; the frame store is not cleared and needs
// no sweep.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module hdlc_like_frame_receiver_crc_check_top (
  input  logic                                clk,
  input  logic                                rst,
  // Slave stream.
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [hdlcrx_pkg::IN_DATA_W-1:0]    s_tdata,  // [7:0] rx_byte, [17:8] tick_ms
  input  logic                                s_tuser,  // [0] func
  // Master stream.
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [hdlcrx_pkg::BYTE_W-1:0]       m_tdata,  // [7:0] out_byte
  output logic [hdlcrx_pkg::KIND_W-1:0]       m_tuser,  // [1:0] kind
  output logic                                m_tlast,  // last
  // Configuration write port.
  input  logic                                cfg_we,
  input  logic                                cfg_index,
  input  logic [hdlcrx_pkg::CFG_W-1:0]        cfg_data
);

  // Control sequencer states.
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_LOAD = 2'd1;
  localparam logic [1:0] ST_OUT  = 2'd2;

  logic [1:0]                          st, st_next;
  logic [1:0]                          phase, phase_next;
  logic [hdlcrx_pkg::CNT_W-1:0]        count, count_next;
  logic [hdlcrx_pkg::TIMER_W-1:0]      timer, timer_next;
  logic [hdlcrx_pkg::TIMER_W-1:0]      idle_timeout;
  logic [hdlcrx_pkg::MIN_W-1:0]        min_len;
  logic [hdlcrx_pkg::ADDR_W-1:0]       rd_idx, rd_idx_next;
  logic [hdlcrx_pkg::ADDR_W-1:0]       last_idx, last_idx_next;

  logic                                acc;
  logic [hdlcrx_pkg::BYTE_W-1:0]       rx_byte;
  logic [hdlcrx_pkg::TICK_W-1:0]       tick_ms;
  logic [hdlcrx_pkg::TIMER_W:0]        tsum;

  logic                                idle_flush;
  logic [1:0]                          ph_eff;
  logic [hdlcrx_pkg::CNT_W-1:0]        cnt_eff;
  logic                                do_store;
  logic [hdlcrx_pkg::BYTE_W-1:0]       store_val;
  logic [1:0]                          ovf_phase;
  logic                                notice_load;
  logic [hdlcrx_pkg::KIND_W-1:0]       notice_kind;

  hdlcrx_pkg::crc_cmd_t                crc_cmd;
  logic [15:0]                         crc;
  logic                                crc_busy;
  hdlcrx_pkg::store_wr_t               wr;
  logic [hdlcrx_pkg::ADDR_W-1:0]       raddr;
  logic [hdlcrx_pkg::BYTE_W-1:0]       rdata;

  assign rx_byte  = s_tdata[7:0];
  assign tick_ms  = s_tdata[17:8];
  assign s_tready = (st == ST_IDLE) && !crc_busy && !m_tvalid;
  assign acc      = s_tvalid && s_tready;
  assign tsum     = {1'b0, timer} + {7'd0, tick_ms};

  // A late byte first flushes the partial frame.
  assign idle_flush = (timer > idle_timeout);
  assign ph_eff     = idle_flush ? hdlcrx_pkg::PH_HUNT : phase;
  assign cnt_eff    = idle_flush ? '0 : count;

  hdlcrx_crc u_crc (
    .clk  (clk),
    .rst  (rst),
    .cmd  (crc_cmd),
    .crc  (crc),
    .busy (crc_busy)
  );

  hdlcrx_store u_store (
    .clk   (clk),
    .wr    (wr),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_comb begin
    st_next       = st;
    phase_next    = phase;
    count_next    = count;
    timer_next    = timer;
    rd_idx_next   = rd_idx;
    last_idx_next = last_idx;
    raddr         = rd_idx;
    do_store      = 1'b0;
    store_val     = rx_byte;
    ovf_phase     = hdlcrx_pkg::PH_HUNT;
    notice_load   = 1'b0;
    notice_kind   = hdlcrx_pkg::KIND_CRC_ERR;
    crc_cmd.start = 1'b0;
    crc_cmd.clear = 1'b0;
    crc_cmd.data  = rx_byte;
    wr.en         = 1'b0;
    wr.addr       = cnt_eff[hdlcrx_pkg::ADDR_W-1:0];
    wr.data       = rx_byte;

    case (st)
      ST_IDLE: begin
        if (acc && (s_tuser == hdlcrx_pkg::FUNC_TICK)) begin
          timer_next = tsum[hdlcrx_pkg::TIMER_W] ? '1 : tsum[hdlcrx_pkg::TIMER_W-1:0];
        end else if (acc) begin
          timer_next    = '0;
          phase_next    = ph_eff;
          count_next    = cnt_eff;
          crc_cmd.clear = idle_flush;
          case (ph_eff)
            hdlcrx_pkg::PH_HUNT: begin
              if (rx_byte == hdlcrx_pkg::FLAG_BYTE) begin
                phase_next = hdlcrx_pkg::PH_BODY;
              end
            end
            hdlcrx_pkg::PH_BODY: begin
              if (rx_byte == hdlcrx_pkg::FLAG_BYTE) begin
                if (hdlcrx_pkg::MIN_W'(cnt_eff) >= min_len) begin
                  // An idle flush leaves the CRC at its initial value.
                  if (!idle_flush && (crc == 16'd0)) begin
                    raddr         = '0;
                    rd_idx_next   = '0;
                    last_idx_next = cnt_eff[hdlcrx_pkg::ADDR_W-1:0] - 1'b1;
                    st_next       = ST_LOAD;
                  end else begin
                    notice_load = 1'b1;
                    notice_kind = hdlcrx_pkg::KIND_CRC_ERR;
                  end
                end
                count_next    = '0;
                crc_cmd.clear = 1'b1;
                phase_next    = hdlcrx_pkg::PH_BODY;
              end else if (rx_byte == hdlcrx_pkg::ESC_BYTE) begin
                phase_next = hdlcrx_pkg::PH_ESC;
              end else begin
                do_store  = 1'b1;
                store_val = rx_byte;
                ovf_phase = hdlcrx_pkg::PH_HUNT;
              end
            end
            hdlcrx_pkg::PH_ESC: begin
              if (rx_byte == hdlcrx_pkg::ESC_OF_FLAG) begin
                do_store  = 1'b1;
                store_val = hdlcrx_pkg::FLAG_BYTE;
                ovf_phase = hdlcrx_pkg::PH_BODY;
              end else if (rx_byte == hdlcrx_pkg::ESC_OF_ESC) begin
                do_store  = 1'b1;
                store_val = hdlcrx_pkg::ESC_BYTE;
                ovf_phase = hdlcrx_pkg::PH_BODY;
              end else begin
                notice_load   = 1'b1;
                notice_kind   = hdlcrx_pkg::KIND_ESC_ERR;
                count_next    = '0;
                crc_cmd.clear = 1'b1;
                phase_next    = hdlcrx_pkg::PH_HUNT;
              end
            end
            default: begin
              count_next    = '0;
              crc_cmd.clear = 1'b1;
              phase_next    = hdlcrx_pkg::PH_HUNT;
            end
          endcase

          // Store into the frame, or flush silently when it is full.
          if (do_store) begin
            if (cnt_eff < hdlcrx_pkg::CNT_W'(hdlcrx_pkg::BUFFER_DEPTH)) begin
              wr.en         = 1'b1;
              wr.data       = store_val;
              crc_cmd.start = 1'b1;
              crc_cmd.data  = store_val;
              count_next    = cnt_eff + 1'b1;
              phase_next    = hdlcrx_pkg::PH_BODY;
            end else begin
              count_next    = '0;
              crc_cmd.clear = 1'b1;
              phase_next    = ovf_phase;
            end
          end
        end
      end
      ST_LOAD: begin
        st_next = ST_OUT;
      end
      ST_OUT: begin
        if (m_tready) begin
          if (m_tlast) begin
            st_next = ST_IDLE;
          end else begin
            rd_idx_next = rd_idx + 1'b1;
            raddr       = rd_idx + 1'b1;
            st_next     = ST_LOAD;
          end
        end
      end
      default: begin
        st_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st     <= ST_IDLE;
      phase  <= hdlcrx_pkg::PH_HUNT;
      count  <= '0;
      timer  <= '0;
      rd_idx <= '0;
    end else begin
      st     <= st_next;
      phase  <= phase_next;
      count  <= count_next;
      timer  <= timer_next;
      rd_idx <= rd_idx_next;
    end
  end

  always_ff @(posedge clk) begin
    last_idx <= last_idx_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idle_timeout <= hdlcrx_pkg::IDLE_TIMEOUT_RST;
      min_len      <= hdlcrx_pkg::MIN_FRAME_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        hdlcrx_pkg::REG_IDLE_TIMEOUT:  idle_timeout <= cfg_data;
        hdlcrx_pkg::REG_MIN_FRAME_LEN: min_len      <= cfg_data[hdlcrx_pkg::MIN_W-1:0];
        default: ;
      endcase
    end
  end

  // Output register: notices load straight from the request, frame bytes
  // from the registered store read. Any result leaves on its handshake.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (notice_load || (st == ST_LOAD)) begin
      m_tvalid <= 1'b1;
    end else if (m_tvalid && m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (notice_load) begin
      m_tuser <= notice_kind;
      m_tdata <= '0;
      m_tlast <= 1'b1;
    end else if (st == ST_LOAD) begin
      m_tuser <= hdlcrx_pkg::KIND_BYTE;
      m_tdata <= rdata;
      m_tlast <= (rd_idx == last_idx);
    end
  end

  `ASSERT_CLK(a_no_req_while_result, m_tvalid |-> !s_tready, "request taken with result pending")
  `ASSERT_CLK(a_count_in_range, count <= hdlcrx_pkg::CNT_W'(hdlcrx_pkg::BUFFER_DEPTH), "count overrun")
  `ASSERT_CLK(a_notice_is_last, m_tvalid && (m_tuser != hdlcrx_pkg::KIND_BYTE) |-> m_tlast && (m_tdata == '0), "notice not last or not zero")
  `ASSERT_NEVER(a_phase_unused, phase == 2'd3, "unused phase reached")

endmodule

### test/tb_hdlc_like_frame_receiver_crc_check_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_hdlc_like_frame_receiver_crc_check_top
// Self-checking bench for the byte-stuffed frame receiver with CRC check.
// A directed part covers flag hunting, escapes, good and bad frames, short
// frames, illegal escapes and the idle flush. Several random phases follow,
// each with its own register setting, among them the extremes: empty frames
// that are checked, the largest frame, store overflow and a minimum length
// that no frame can reach. Every result is compared with a cycle-free
// prediction of the receiver kept by a small scoreboard.
// ---------------------------------------------------------------------------

module tb_hdlc_like_frame_receiver_crc_check_top;

  // Cycles to let a stored byte leave the CRC unit before a register write.
  localparam int SETTLE_CYCLES  = 8;
  // Cycles without any handshake before the run is declared hung.
  localparam int WATCHDOG_LIMIT = 1000;

  // One result as it leaves the master stream.
  typedef struct packed {
    logic [hdlcrx_pkg::KIND_W-1:0] kind;
    logic [hdlcrx_pkg::BYTE_W-1:0] data;
    logic                          last;
  } rx_result_t;

  // Tracks the receiver state request by request and holds the results that
  // are still due on the master stream.
  class rx_frame_tracker;
    logic [hdlcrx_pkg::TIMER_W-1:0] idle_timeout;
    logic [hdlcrx_pkg::MIN_W-1:0]   min_len;
    logic [1:0]                     phase;
    logic [hdlcrx_pkg::BYTE_W-1:0]  store [hdlcrx_pkg::BUFFER_DEPTH];
    int                             count;
    logic [15:0]                    crc;
    int                             idle_ms;
    rx_result_t                     due_results[$];
    int                             errors;
    int                             bytes_checked;
    int                             frames_released;
    int                             crc_notices;
    int                             esc_notices;

    function new();
      idle_timeout    = hdlcrx_pkg::IDLE_TIMEOUT_RST;
      min_len         = hdlcrx_pkg::MIN_FRAME_RST;
      idle_ms         = 0;
      errors          = 0;
      bytes_checked   = 0;
      frames_released = 0;
      crc_notices     = 0;
      esc_notices     = 0;
      flush();
    endfunction

    // CRC-16/CCITT over one byte, most significant bit first.
    static function logic [15:0] crc_step(logic [15:0] c, logic [hdlcrx_pkg::BYTE_W-1:0] b);
      logic [15:0] r;
      r = c ^ {b, 8'h00};
      for (int i = 0; i < 8; i++) begin
        r = r[15] ? ((r << 1) ^ hdlcrx_pkg::CRC_POLY) : (r << 1);
      end
      return r;
    endfunction

    function void write_reg(logic idx, logic [hdlcrx_pkg::CFG_W-1:0] v);
      if (idx == hdlcrx_pkg::REG_IDLE_TIMEOUT) idle_timeout = v;
      else min_len = v[hdlcrx_pkg::MIN_W-1:0];
    endfunction

    function void flush();
      phase = hdlcrx_pkg::PH_HUNT;
      count = 0;
      crc   = hdlcrx_pkg::CRC_INIT;
    endfunction

    // A byte that finds the store full is lost and the frame is dropped.
    function void put_byte(logic [hdlcrx_pkg::BYTE_W-1:0] b);
      if (count < hdlcrx_pkg::BUFFER_DEPTH) begin
        store[count] = b;
        crc = crc_step(crc, b);
        count++;
      end else begin
        flush();
      end
    endfunction

    function void push_result(logic [hdlcrx_pkg::KIND_W-1:0] kind,
                              logic [hdlcrx_pkg::BYTE_W-1:0] data, logic last);
      rx_result_t r;
      r.kind = kind;
      r.data = data;
      r.last = last;
      due_results.push_back(r);
    endfunction

    function void note_request(logic func, logic [hdlcrx_pkg::BYTE_W-1:0] b,
                               logic [hdlcrx_pkg::TICK_W-1:0] ms);
      if (func == hdlcrx_pkg::FUNC_TICK) begin
        idle_ms = idle_ms + ms;
        if (idle_ms > 65535) idle_ms = 65535;
        return;
      end
      // A long silence on the line ends any partial frame first.
      if (idle_ms > idle_timeout) flush();
      idle_ms = 0;
      case (phase)
        hdlcrx_pkg::PH_HUNT: begin
          if (b == hdlcrx_pkg::FLAG_BYTE) phase = hdlcrx_pkg::PH_BODY;
        end
        hdlcrx_pkg::PH_BODY: begin
          if (b == hdlcrx_pkg::FLAG_BYTE) begin
            if (count >= min_len) begin
              if (crc == 16'h0000) begin
                for (int i = 0; i < count; i++) begin
                  push_result(hdlcrx_pkg::KIND_BYTE, store[i], i == count - 1);
                end
              end else begin
                push_result(hdlcrx_pkg::KIND_CRC_ERR, '0, 1'b1);
              end
            end
            // The closing flag doubles as the opening flag of the next frame.
            flush();
            phase = hdlcrx_pkg::PH_BODY;
          end else if (b == hdlcrx_pkg::ESC_BYTE) begin
            phase = hdlcrx_pkg::PH_ESC;
          end else begin
            put_byte(b);
          end
        end
        hdlcrx_pkg::PH_ESC: begin
          // An overflow on an escaped byte still leaves the receiver in body.
          if (b == hdlcrx_pkg::ESC_OF_FLAG) begin
            put_byte(hdlcrx_pkg::FLAG_BYTE);
            phase = hdlcrx_pkg::PH_BODY;
          end else if (b == hdlcrx_pkg::ESC_OF_ESC) begin
            put_byte(hdlcrx_pkg::ESC_BYTE);
            phase = hdlcrx_pkg::PH_BODY;
          end else begin
            push_result(hdlcrx_pkg::KIND_ESC_ERR, '0, 1'b1);
            flush();
          end
        end
        default: flush();
      endcase
    endfunction

    task report_mismatch(string what);
      errors++;
      $display("[%0t] mismatch: %s", $time, what);
    endtask

    task check_result(logic [hdlcrx_pkg::KIND_W-1:0] kind,
                      logic [hdlcrx_pkg::BYTE_W-1:0] data, logic last);
      rx_result_t want;
      if (due_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result kind %0d byte %02h last %0b",
                                  kind, data, last));
        return;
      end
      want = due_results.pop_front();
      if (kind !== want.kind)
        report_mismatch($sformatf("kind %0d, expected %0d", kind, want.kind));
      if (data !== want.data)
        report_mismatch($sformatf("byte %02h, expected %02h", data, want.data));
      if (last !== want.last)
        report_mismatch($sformatf("last %0b, expected %0b", last, want.last));
      case (want.kind)
        hdlcrx_pkg::KIND_BYTE: begin
          bytes_checked++;
          if (want.last) frames_released++;
        end
        hdlcrx_pkg::KIND_CRC_ERR: crc_notices++;
        default: esc_notices++;
      endcase
    endtask
  endclass

  logic                            clk       = 1'b0;
  logic                            rst       = 1'b1;
  logic                            s_tvalid  = 1'b0;
  logic                            s_tready;
  logic [hdlcrx_pkg::IN_DATA_W-1:0] s_tdata  = '0;
  logic                            s_tuser   = hdlcrx_pkg::FUNC_BYTE;
  logic                            m_tvalid;
  logic                            m_tready  = 1'b1;
  logic [hdlcrx_pkg::BYTE_W-1:0]   m_tdata;
  logic [hdlcrx_pkg::KIND_W-1:0]   m_tuser;
  logic                            m_tlast;
  logic                            cfg_we    = 1'b0;
  logic                            cfg_index = hdlcrx_pkg::REG_IDLE_TIMEOUT;
  logic [hdlcrx_pkg::CFG_W-1:0]    cfg_data  = '0;

  rx_frame_tracker                 board;
  logic [hdlcrx_pkg::BYTE_W-1:0]   payload_q[$];
  bit                              idling_on = 1'b1;
  int                              stall_left = 0;
  int                              quiet_cycles = 0;
  int                              items_sent = 0;
  int                              settings_used = 0;

  hdlc_like_frame_receiver_crc_check_top DUT (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #1 clk = ~clk;

  // Both handshakes are sampled at the rising edge, where every bench input
  // still holds the value driven before the edge.
  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) board.note_request(s_tuser, s_tdata[7:0], s_tdata[17:8]);
      if (m_tvalid && m_tready) board.check_result(m_tuser, m_tdata, m_tlast);
    end
  end

  // The receiver stalls at random while idling is on.
  always @(posedge clk) begin
    if (!idling_on) begin
      m_tready <= 1'b1;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      m_tready   <= 1'b0;
    end else if ($urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(0, 10);
      m_tready   <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  // A stretch with no handshake at all means the block has hung.
  always @(posedge clk) begin
    if (rst || cfg_we || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == WATCHDOG_LIMIT) begin
        $display("[%0t] watchdog: no handshake for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("Some tests failed");
        $finish;
      end
    end
  end

  // Offers one request and returns in the time step of its handshake, so the
  // caller drives the next request or lowers tvalid in that same step.
  task automatic send_request(input logic func, input logic [hdlcrx_pkg::BYTE_W-1:0] b,
                              input logic [hdlcrx_pkg::TICK_W-1:0] ms);
    if (idling_on && $urandom_range(0, 4) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= func;
    s_tdata  <= {6'd0, ms, b};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    items_sent++;
  endtask

  // The unused field of each request carries random bits.
  task automatic send_byte(input logic [hdlcrx_pkg::BYTE_W-1:0] b);
    send_request(hdlcrx_pkg::FUNC_BYTE, b, hdlcrx_pkg::TICK_W'($urandom_range(0, 1023)));
  endtask

  task automatic send_tick(input logic [hdlcrx_pkg::TICK_W-1:0] ms);
    send_request(hdlcrx_pkg::FUNC_TICK, hdlcrx_pkg::BYTE_W'($urandom_range(0, 255)), ms);
  endtask

  task automatic send_escaped(input logic [hdlcrx_pkg::BYTE_W-1:0] b);
    if (b == hdlcrx_pkg::FLAG_BYTE) begin
      send_byte(hdlcrx_pkg::ESC_BYTE);
      send_byte(hdlcrx_pkg::ESC_OF_FLAG);
    end else if (b == hdlcrx_pkg::ESC_BYTE) begin
      send_byte(hdlcrx_pkg::ESC_BYTE);
      send_byte(hdlcrx_pkg::ESC_OF_ESC);
    end else begin
      send_byte(b);
    end
  endtask

  // Line bytes lean toward the codes that the receiver treats specially.
  function automatic logic [hdlcrx_pkg::BYTE_W-1:0] pick_line_byte();
    case ($urandom_range(0, 9))
      0: return hdlcrx_pkg::FLAG_BYTE;
      1: return hdlcrx_pkg::ESC_BYTE;
      2: return hdlcrx_pkg::ESC_OF_FLAG;
      3: return hdlcrx_pkg::ESC_OF_ESC;
      default: return hdlcrx_pkg::BYTE_W'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic void fill_payload(input int len);
    payload_q.delete();
    repeat (len) payload_q.push_back(pick_line_byte());
  endfunction

  // Sends payload_q stuffed, followed by its CRC, high byte first, and a
  // closing flag. Ticks can be slipped into the middle of the body.
  task automatic send_frame(input bit open_flag, input bit bad_crc, input int mid_ticks,
                            input logic [hdlcrx_pkg::TICK_W-1:0] mid_ms);
    logic [15:0] fcs;
    fcs = hdlcrx_pkg::CRC_INIT;
    foreach (payload_q[i]) fcs = rx_frame_tracker::crc_step(fcs, payload_q[i]);
    if (bad_crc) fcs = fcs ^ (16'h0001 << $urandom_range(0, 15));
    if (open_flag) send_byte(hdlcrx_pkg::FLAG_BYTE);
    foreach (payload_q[i]) begin
      if (i == payload_q.size() / 2) repeat (mid_ticks) send_tick(mid_ms);
      send_escaped(payload_q[i]);
    end
    send_escaped(fcs[15:8]);
    send_escaped(fcs[7:0]);
    send_byte(hdlcrx_pkg::FLAG_BYTE);
  endtask

  // Two flags leave the receiver in body with an empty store from any phase.
  task automatic sync_to_body();
    send_byte(hdlcrx_pkg::FLAG_BYTE);
    send_byte(hdlcrx_pkg::FLAG_BYTE);
  endtask

  // Fills the store and then offers one byte more, plain or escaped.
  task automatic overflow_store(input bit via_escape);
    sync_to_body();
    // Fill bytes stay below the escape code, one request each.
    payload_q.delete();
    repeat (hdlcrx_pkg::BUFFER_DEPTH)
      payload_q.push_back(hdlcrx_pkg::BYTE_W'($urandom_range(0, 124)));
    foreach (payload_q[i]) send_escaped(payload_q[i]);
    if (via_escape) begin
      send_byte(hdlcrx_pkg::ESC_BYTE);
      send_byte(hdlcrx_pkg::ESC_OF_FLAG);
    end else begin
      send_byte(8'h41);
    end
    // Released only if the receiver stayed in body after the overflow.
    fill_payload(2);
    send_frame(1'b0, 1'b0, 0, '0);
  endtask

  // The scoreboard is read between edges, after the last request is noted.
  task automatic wait_results();
    s_tvalid <= 1'b0;
    @(negedge clk);
    while (board.due_results.size() != 0) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic set_registers(input logic [hdlcrx_pkg::CFG_W-1:0] timeout,
                               input logic [hdlcrx_pkg::CFG_W-1:0] min_len);
    wait_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= hdlcrx_pkg::REG_IDLE_TIMEOUT;
    cfg_data  <= timeout;
    @(posedge clk);
    board.write_reg(hdlcrx_pkg::REG_IDLE_TIMEOUT, timeout);
    cfg_index <= hdlcrx_pkg::REG_MIN_FRAME_LEN;
    cfg_data  <= min_len;
    @(posedge clk);
    board.write_reg(hdlcrx_pkg::REG_MIN_FRAME_LEN, min_len);
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  // Mostly well-formed frames with random content; the rest is stray bytes,
  // ticks, illegal escapes and frames cut short.
  task automatic random_traffic(input int n_items, input int min_pay, input int max_pay);
    int stop_at;
    int choice;
    logic [hdlcrx_pkg::BYTE_W-1:0] bad;
    stop_at = items_sent + n_items;
    while (items_sent < stop_at) begin
      choice = $urandom_range(0, 9);
      if (choice <= 5) begin
        fill_payload($urandom_range(min_pay, max_pay));
        send_frame($urandom_range(0, 1) == 0, $urandom_range(0, 3) == 0,
                   ($urandom_range(0, 4) == 0) ? 1 : 0,
                   hdlcrx_pkg::TICK_W'($urandom_range(0, 31)));
        // Now and then the sender holds off until the frame has drained.
        if ($urandom_range(0, 5) == 0) wait_results();
      end else if (choice == 6) begin
        send_byte(pick_line_byte());
      end else if (choice == 7) begin
        send_tick(hdlcrx_pkg::TICK_W'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 1023)
                                                                  : $urandom_range(0, 8)));
      end else if (choice == 8) begin
        do bad = hdlcrx_pkg::BYTE_W'($urandom_range(0, 255));
        while (bad == hdlcrx_pkg::ESC_OF_FLAG || bad == hdlcrx_pkg::ESC_OF_ESC);
        send_byte(hdlcrx_pkg::ESC_BYTE);
        send_byte(bad);
      end else begin
        send_byte(hdlcrx_pkg::FLAG_BYTE);
        repeat ($urandom_range(1, 3)) send_byte(pick_line_byte());
      end
    end
  endtask

  initial begin
    board = new();
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Directed part, with a two byte minimum so that short frames are checked.
    set_registers(16'd20, 16'd2);
    send_tick(10'd1023);
    send_tick(10'd0);
    send_byte(8'h00);            // Flushes on the idle gap, then stays in hunt.
    send_byte(8'hFF);
    send_byte(hdlcrx_pkg::FLAG_BYTE);
    payload_q = '{hdlcrx_pkg::FLAG_BYTE, hdlcrx_pkg::ESC_BYTE, 8'hFF, 8'h00};
    send_frame(1'b0, 1'b0, 0, '0);
    send_byte(8'h11);            // Wrong CRC gives one notice.
    send_byte(8'h22);
    send_byte(hdlcrx_pkg::FLAG_BYTE);
    send_byte(8'h44);            // The gap drops 44, so the next frame is short.
    send_tick(10'd30);
    send_byte(hdlcrx_pkg::FLAG_BYTE);
    send_byte(8'h33);
    send_byte(hdlcrx_pkg::FLAG_BYTE);
    send_byte(hdlcrx_pkg::ESC_BYTE);   // A flag right after an escape is illegal.
    send_byte(hdlcrx_pkg::FLAG_BYTE);
    send_byte(hdlcrx_pkg::FLAG_BYTE);
    send_byte(hdlcrx_pkg::ESC_BYTE);
    send_byte(8'h00);

    // Random phases, each under its own register setting.
    set_registers(16'd20, 16'd12);
    random_traffic(20, 9, 14);

    // Zero minimum checks empty frames; zero timeout flushes on any nonzero tick.
    set_registers(16'd0, 16'd0);
    random_traffic(14, 0, 3);

    // Largest frame the store holds, with two long ticks in the middle.
    set_registers(16'hFFFF, 16'd64);
    sync_to_body();
    fill_payload(hdlcrx_pkg::BUFFER_DEPTH - 2);
    send_frame(1'b0, 1'b0, 2, 10'd1023);
    random_traffic(6, 2, 6);

    set_registers(16'd1023, 16'd3);
    overflow_store(1'b1);
    overflow_store(1'b0);
    random_traffic(10, 0, 6);

    // A minimum above the store depth means no frame is ever checked.
    set_registers(16'd20, 16'd127);
    random_traffic(8, 0, 4);

    // Final stretch runs without any idling on either side.
    set_registers(16'd5, 16'd4);
    idling_on <= 1'b0;
    random_traffic(14, 2, 8);

    wait_results();
    repeat (10) @(posedge clk);
    if (board.due_results.size() != 0)
      board.report_mismatch($sformatf("%0d results never arrived", board.due_results.size()));

    $display("Sent %0d requests under %0d register settings.", items_sent, settings_used);
    $display("Released %0d frames (%0d bytes), %0d CRC notices, %0d escape notices.",
             board.frames_released, board.bytes_checked, board.crc_notices,
             board.esc_notices);
    if (board.errors == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

endmodule

### files.f
+incdir+hw/rtl
hw/rtl/hdlcrx_pkg.sv
hw/rtl/hdlcrx_crc.sv
hw/rtl/hdlcrx_store.sv
hw/rtl/hdlc_like_frame_receiver_crc_check_top.sv
test/tb_hdlc_like_frame_receiver_crc_check_top.sv
